>>> sv/lob_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Order book package
// Shared types, constants and codes for the limit order book matcher.
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int unsigned BookDepth   = 16;
  localparam int unsigned SymbolChars = 8;
  localparam int unsigned MaxResults  = 32;
  localparam int unsigned SlotW       = $clog2(BookDepth);
  localparam int unsigned CntW        = $clog2(MaxResults + 1);

  localparam logic [7:0] CharBuy  = 8'h42;
  localparam logic [7:0] CharSell = 8'h53;

  typedef enum logic [1:0] {
    OP_PLACE  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_PRINT  = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_FILL   = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_ENTRY  = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ERR_ACTION    = 4'd0,
    ERR_DUPLICATE = 4'd1,
    ERR_SYM_LONG  = 4'd2,
    ERR_SYM_MISS  = 4'd3,
    ERR_SIDE      = 4'd4,
    ERR_QTY       = 4'd5,
    ERR_PX        = 4'd6,
    ERR_NOT_FOUND = 4'd7,
    ERR_EMPTY     = 4'd8,
    ERR_FULL      = 4'd9
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_DECODE,
    ST_SCAN,
    ST_FILL_IN,
    ST_FILL_REST,
    ST_REST,
    ST_PSCAN,
    ST_PEMIT,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  latch;       // capture the input transaction
    logic  scan_clr;    // restart the slot scan
    logic  scan_step;   // examine one slot
    logic  prt;         // the scan ranks by print order
    logic  emit_err;    // present an error result
    err_e  err;
    logic  emit_ok;     // present a cancel confirmation
    logic  cancel;      // free the found slot
    logic  emit_in;     // incoming fill
    logic  emit_rest;   // resting fill, and update the resting slot
    logic  rest;        // rest the remainder
    logic  emit_entry;  // book entry for the selected slot
    logic  last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             scan_end;
    logic             found;
    logic             best_ok;
    logic             more_match;
    logic             free_ok;
    logic             any_valid;
    logic             qty_left;
    logic             more_print;
    err_e             chk_err;
    logic             chk_bad;
    logic [CntW-1:0]  n;
  } stat_t;

endpackage : lob_pkg
`default_nettype wire

>>> sv/limit_order_book_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limit order book matcher
// Price-time priority order book over one shared sixteen-slot store.
// ----------------------------------------------------------------------------
// An error, cancel or unknown transaction gives its one result after the id
// search and the decode step. A place adds a slot scan plus two results per
// match, print a slot scan and one result per entry. busy falls once the final
// result is out, so one transaction is in flight at a time; the receiver
// cannot stall.
// Reset empties the book at once and clears the arrival count.
module limit_order_book_matcher import lob_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   operation_i,
  input  wire logic [31:0]  order_id_i,
  input  wire logic [63:0]  symbol_i,
  input  wire logic [3:0]   symbol_length_i,
  input  wire logic [7:0]   side_char_i,
  input  wire logic [15:0]  quantity_i,
  input  wire logic signed [39:0] limit_price_i,
  output logic              result_valid_o,
  output logic [1:0]        result_kind_o,
  output logic [31:0]       result_order_id_o,
  output logic [63:0]       result_symbol_o,
  output logic              result_side_o,
  output logic [15:0]       result_qty_o,
  output logic [38:0]       result_price_o,
  output logic [3:0]        error_code_o,
  output logic              last_of_run_o
);

  cmd_t  cmd;
  stat_t st;

  lob_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .busy_o      (busy),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  lob_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .order_id_i        (order_id_i),
    .symbol_i          (symbol_i),
    .symbol_length_i   (symbol_length_i),
    .side_char_i       (side_char_i),
    .quantity_i        (quantity_i),
    .limit_price_i     (limit_price_i),
    .cmd_i             (cmd),
    .st_o              (st),
    .result_valid_o    (result_valid_o),
    .result_kind_o     (result_kind_o),
    .result_order_id_o (result_order_id_o),
    .result_symbol_o   (result_symbol_o),
    .result_side_o     (result_side_o),
    .result_qty_o      (result_qty_o),
    .result_price_o    (result_price_o),
    .error_code_o      (error_code_o),
    .last_of_run_o     (last_of_run_o)
  );

endmodule : limit_order_book_matcher
`default_nettype wire

>>> sv/lob_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Order book controller
// Sequences find, check, match, rest and print steps of one transaction.
// ----------------------------------------------------------------------------
module lob_ctrl import lob_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire logic [1:0] operation_i,
  output logic       busy_o,
  output cmd_t       cmd_o,
  input  stat_t      st_i
);

  state_e state_q, state_d;
  op_e    op_q;
  logic   again;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_PLACE;
    end else begin
      state_q <= state_d;
      if (start_i && state_q == ST_IDLE) op_q <= op_e'(operation_i);
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // Another fill pair follows only if quantity is left, a second candidate
  // was seen in the last scan and the result budget allows one more pair.
  assign again = st_i.qty_left && st_i.more_match &&
                 (st_i.n <= CntW'(MaxResults - 2));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (start_i) state_d = ST_FIND;
      ST_FIND:      if (st_i.scan_end) state_d = ST_DECODE;
      ST_DECODE: begin
        case (op_q)
          OP_PLACE:  state_d = st_i.chk_bad ? ST_IDLE : ST_SCAN;
          OP_PRINT:  state_d = st_i.any_valid ? ST_PSCAN : ST_IDLE;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (st_i.scan_end) begin
          state_d = st_i.best_ok ? ST_FILL_IN : ST_REST;
        end
      end
      ST_FILL_IN:   state_d = ST_FILL_REST;
      ST_FILL_REST: begin
        if (again) begin
          state_d = ST_SCAN;
        end else if (st_i.qty_left) begin
          state_d = ST_REST;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_REST:      state_d = ST_IDLE;
      ST_PSCAN:     if (st_i.scan_end) state_d = ST_PEMIT;
      ST_PEMIT:     state_d = st_i.more_print ? ST_PSCAN : ST_IDLE;
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.err = ERR_ACTION;
    case (state_q)
      ST_IDLE: begin
        cmd_o.latch    = start_i;
        cmd_o.scan_clr = 1'b1;
      end
      ST_FIND: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_DECODE: begin
        cmd_o.scan_clr = 1'b1;
        cmd_o.last     = 1'b1;
        case (op_q)
          OP_PLACE: begin
            cmd_o.emit_err = st_i.chk_bad;
            cmd_o.err      = st_i.chk_err;
          end
          OP_CANCEL: begin
            cmd_o.emit_err = !st_i.found;
            cmd_o.err      = ERR_NOT_FOUND;
            cmd_o.emit_ok  = st_i.found;
            cmd_o.cancel   = st_i.found;
          end
          OP_PRINT: begin
            cmd_o.emit_err = !st_i.any_valid;
            cmd_o.err      = ERR_EMPTY;
          end
          default: begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err      = ERR_ACTION;
          end
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_FILL_IN: cmd_o.emit_in = 1'b1;
      ST_FILL_REST: begin
        cmd_o.emit_rest = 1'b1;
        cmd_o.scan_clr  = 1'b1;
        // A remainder after a fill always finds the emptied slot, so it rests
        // without a result and this fill closes the run.
        cmd_o.last = !again;
      end
      ST_REST: begin
        cmd_o.rest     = st_i.free_ok && st_i.qty_left;
        cmd_o.emit_err = !st_i.free_ok && st_i.qty_left && (st_i.n < CntW'(MaxResults));
        cmd_o.err      = ERR_FULL;
        cmd_o.last     = 1'b1;
      end
      ST_PSCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.prt       = 1'b1;
      end
      ST_PEMIT: begin
        cmd_o.emit_entry = 1'b1;
        cmd_o.scan_clr   = 1'b1;
        cmd_o.last       = !st_i.more_print;
      end
      default: ;
    endcase
  end

  // A result strobe only leaves a working state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_in || cmd_o.emit_rest) |-> busy_o)
    else $error("fill outside a transaction");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL_IN |=> state_q == ST_FILL_REST)
    else $error("fill pair broken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> state_q == ST_FIND)
    else $error("start not taken");

endmodule : lob_ctrl
`default_nettype wire

>>> sv/lob_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Order book datapath
// Slot store, one-slot-per-cycle scan unit and result register.
// ----------------------------------------------------------------------------
module lob_dp import lob_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [31:0]  order_id_i,
  input  wire logic [63:0]  symbol_i,
  input  wire logic [3:0]   symbol_length_i,
  input  wire logic [7:0]   side_char_i,
  input  wire logic [15:0]  quantity_i,
  input  wire logic signed [39:0] limit_price_i,
  input  cmd_t              cmd_i,
  output stat_t             st_o,
  output logic              result_valid_o,
  output logic [1:0]        result_kind_o,
  output logic [31:0]       result_order_id_o,
  output logic [63:0]       result_symbol_o,
  output logic              result_side_o,
  output logic [15:0]       result_qty_o,
  output logic [38:0]       result_price_o,
  output logic [3:0]        error_code_o,
  output logic              last_of_run_o
);

  logic [BookDepth-1:0] valid_q;
  logic [BookDepth-1:0] printed_q;
  logic [31:0] sid_q  [BookDepth];
  logic [63:0] ssym_q [BookDepth];
  logic        sside_q[BookDepth];
  logic [15:0] sqty_q [BookDepth];
  logic [38:0] spx_q  [BookDepth];
  logic [31:0] sarr_q [BookDepth];
  logic [31:0] arrival_q;

  logic [31:0] id_q;
  logic [63:0] sym_q;
  logic [3:0]  len_q;
  logic [7:0]  sc_q;
  logic [15:0] qty_q;
  logic [39:0] px_q;
  logic [CntW-1:0] n_q;

  logic [SlotW:0]   idx_q;
  logic             found_q, best_ok_q, free_ok_q, multi_q;
  logic [SlotW-1:0] found_s_q, best_s_q, free_s_q;

  logic [SlotW-1:0] idx;
  logic             side_in;
  logic [63:0]      sym_eff;
  logic [15:0]      fill;

  assign idx     = idx_q[SlotW-1:0];
  assign side_in = (sc_q == CharSell);
  assign fill    = (qty_q < sqty_q[best_s_q]) ? qty_q : sqty_q[best_s_q];

  always_comb begin
    sym_eff = sym_q;
    for (int k = 1; k < 8; k++) begin
      if (len_q == 4'(k)) sym_eff = sym_q & ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * k));
    end
  end

  // Scan candidate tests for the current slot.
  logic cand, better, pbetter;
  logic [31:0] age_c, age_b;
  assign age_c = arrival_q - sarr_q[idx];
  assign age_b = arrival_q - sarr_q[best_s_q];

  always_comb begin
    cand = !cmd_i.prt && valid_q[idx] && (sside_q[idx] != side_in) &&
           (ssym_q[idx] == sym_eff) &&
           (side_in ? (spx_q[idx] >= px_q[38:0]) : (spx_q[idx] <= px_q[38:0]));
    if (spx_q[idx] != spx_q[best_s_q]) begin
      better = side_in ? (spx_q[idx] > spx_q[best_s_q]) : (spx_q[idx] < spx_q[best_s_q]);
    end else begin
      better = age_c > age_b;
    end
    if (sside_q[idx] != sside_q[best_s_q]) begin
      pbetter = sside_q[idx];
    end else if (spx_q[idx] != spx_q[best_s_q]) begin
      pbetter = spx_q[idx] > spx_q[best_s_q];
    end else begin
      pbetter = sside_q[idx] ? (age_c < age_b) : (age_c > age_b);
    end
  end

  logic scan_end;
  assign scan_end = (idx_q == (SlotW + 1)'(BookDepth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      printed_q      <= '0;
      arrival_q      <= '0;
      n_q            <= '0;
      idx_q          <= '0;
      found_q        <= 1'b0;
      best_ok_q      <= 1'b0;
      free_ok_q      <= 1'b0;
      multi_q        <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cmd_i.latch) begin
        n_q       <= '0;
        found_q   <= 1'b0;
        printed_q <= '0;
      end
      if (cmd_i.scan_clr) begin
        idx_q     <= '0;
        best_ok_q <= 1'b0;
        multi_q   <= 1'b0;
        // A resting order that this fill empties leaves its slot free.
        free_ok_q <= cmd_i.emit_rest && (sqty_q[best_s_q] == fill);
        free_s_q  <= best_s_q;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
        if (valid_q[idx] && sid_q[idx] == id_q) begin
          found_q   <= 1'b1;
          found_s_q <= idx;
        end
        if (!valid_q[idx] && !free_ok_q) begin
          free_ok_q <= 1'b1;
          free_s_q  <= idx;
        end
        if (cand && best_ok_q) multi_q <= 1'b1;
        // Print selection reuses best: next unprinted valid slot in order.
        if (cmd_i.prt) begin
          if (valid_q[idx] && !printed_q[idx] && (!best_ok_q || pbetter)) begin
            best_ok_q <= 1'b1;
            best_s_q  <= idx;
          end
        end else if (cand && (!best_ok_q || better)) begin
          best_ok_q <= 1'b1;
          best_s_q  <= idx;
        end
      end
      if (cmd_i.emit_err || cmd_i.emit_ok || cmd_i.emit_in || cmd_i.emit_rest ||
          cmd_i.emit_entry) begin
        result_valid_o <= 1'b1;
        n_q            <= n_q + 1'b1;
      end
      if (cmd_i.cancel) valid_q[found_s_q] <= 1'b0;
      if (cmd_i.emit_rest) begin
        sqty_q[best_s_q] <= sqty_q[best_s_q] - fill;
        if (sqty_q[best_s_q] == fill) valid_q[best_s_q] <= 1'b0;
      end
      if (cmd_i.emit_entry) printed_q[best_s_q] <= 1'b1;
      if (cmd_i.rest) begin
        valid_q[free_s_q] <= 1'b1;
        sid_q[free_s_q]   <= id_q;
        ssym_q[free_s_q]  <= sym_eff;
        sside_q[free_s_q] <= side_in;
        sqty_q[free_s_q]  <= qty_q;
        spx_q[free_s_q]   <= px_q[38:0];
        sarr_q[free_s_q]  <= arrival_q;
        arrival_q         <= arrival_q + 32'd1;
      end
    end
  end

  // Transaction fields, held for the whole transaction; the open quantity
  // drops with each fill.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      id_q  <= order_id_i;
      sym_q <= symbol_i;
      len_q <= symbol_length_i;
      sc_q  <= side_char_i;
      qty_q <= quantity_i;
      px_q  <= limit_price_i;
    end else if (cmd_i.emit_rest) begin
      qty_q <= qty_q - fill;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    result_kind_o     <= KIND_ERROR;
    result_order_id_o <= id_q;
    result_symbol_o   <= '0;
    result_side_o     <= 1'b0;
    result_qty_o      <= '0;
    result_price_o    <= '0;
    error_code_o      <= cmd_i.emit_err ? cmd_i.err : ERR_ACTION;
    last_of_run_o     <= cmd_i.last;
    if (cmd_i.emit_ok) result_kind_o <= KIND_CANCEL;
    if (cmd_i.emit_in || cmd_i.emit_rest) begin
      result_kind_o   <= KIND_FILL;
      result_symbol_o <= sym_eff;
      result_qty_o    <= fill;
      result_price_o  <= spx_q[best_s_q];
      if (cmd_i.emit_rest) result_order_id_o <= sid_q[best_s_q];
    end
    if (cmd_i.emit_entry) begin
      result_kind_o     <= KIND_ENTRY;
      result_order_id_o <= sid_q[best_s_q];
      result_symbol_o   <= ssym_q[best_s_q];
      result_side_o     <= sside_q[best_s_q];
      result_qty_o      <= sqty_q[best_s_q];
      result_price_o    <= spx_q[best_s_q];
    end
  end

  always_comb begin
    st_o            = '0;
    st_o.scan_end   = scan_end;
    st_o.found      = found_q;
    st_o.best_ok    = best_ok_q || (cmd_i.scan_step && cand);
    st_o.more_match = multi_q;
    st_o.free_ok    = free_ok_q;
    st_o.any_valid  = |valid_q;
    st_o.qty_left   = cmd_i.emit_rest ? (qty_q != fill) : (qty_q != 16'd0);
    st_o.more_print = |(valid_q & ~printed_q & ~(BookDepth'(1) << best_s_q)) &&
                      (n_q < CntW'(MaxResults - 1));
    st_o.n          = n_q + 1'b1;
    st_o.chk_bad    = 1'b1;
    if (found_q)                            st_o.chk_err = ERR_DUPLICATE;
    else if (len_q > 4'(SymbolChars))       st_o.chk_err = ERR_SYM_LONG;
    else if (len_q == 4'd0)                 st_o.chk_err = ERR_SYM_MISS;
    else if (sc_q != CharBuy && sc_q != CharSell) st_o.chk_err = ERR_SIDE;
    else if (qty_q == 16'd0)                st_o.chk_err = ERR_QTY;
    else if (px_q == 40'd0 || px_q[39])     st_o.chk_err = ERR_PX;
    else begin
      st_o.chk_err = ERR_ACTION;
      st_o.chk_bad = 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rest |-> free_ok_q && !valid_q[free_s_q])
    else $error("rest into an occupied slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_rest |-> valid_q[best_s_q] && fill != 16'd0)
    else $error("fill against an empty slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.latch |=> n_q == '0)
    else $error("result count not cleared");

endmodule : lob_dp
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book matcher testbench
// Sends place, cancel, print and unknown transactions to the matcher, first as
// a directed sequence and then at random. The expected result stream is
// predicted from a model of the book kept here and compared with every result.
// ----------------------------------------------------------------------------
module testbench;
  import lob_pkg::*;

  localparam int unsigned StallLimit = 6000;

  typedef struct {
    op_e                op;
    logic [31:0]        id;
    logic [63:0]        sym;
    logic [3:0]         len;
    logic [7:0]         side_char;
    logic [15:0]        qty;
    logic signed [39:0] px;
  } order_req_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] id;
    logic [63:0] sym;
    logic        side;
    logic [15:0] qty;
    logic [38:0] px;
    err_e        err;
    logic        last;
  } book_result_t;

  class lob_scoreboard;
    bit           live[BookDepth];
    bit [31:0]    oid[BookDepth];
    bit [63:0]    osym[BookDepth];
    bit           oside[BookDepth];
    bit [15:0]    oqty[BookDepth];
    bit [38:0]    opx[BookDepth];
    bit [31:0]    oarr[BookDepth];
    bit [31:0]    arrivals;
    book_result_t awaited_q[$];
    int           mismatches;
    int           results_seen;
    int           fills_seen;

    function void add(kind_e k, bit [31:0] id, bit [63:0] sym, bit sd, bit [15:0] q,
                      bit [38:0] p, err_e e);
      book_result_t r;
      r.kind = k; r.id = id; r.sym = sym; r.side = sd; r.qty = q; r.px = p;
      r.err = e; r.last = 1'b0;
      awaited_q = {awaited_q, r};
    endfunction

    function void add_error(bit [31:0] id, err_e e);
      add(KIND_ERROR, id, '0, 1'b0, '0, '0, e);
    endfunction

    function int slot_of(bit [31:0] id);
      for (int s = 0; s < BookDepth; s++)
        if (live[s] && oid[s] == id) return s;
      return -1;
    endfunction

    function bit [31:0] age(int s);
      return arrivals - oarr[s];
    endfunction

    // Sells from the top price down, newest first; then buys from the top
    // price down, oldest first.
    function bit lists_first(int a, int b);
      if (oside[a] != oside[b]) return oside[a];
      if (opx[a] != opx[b]) return opx[a] > opx[b];
      if (oside[a]) return age(a) < age(b);
      return age(a) > age(b);
    endfunction

    function int resting_id_count();
      int c;
      c = 0;
      foreach (live[s]) c += live[s];
      return c;
    endfunction

    function bit [31:0] any_resting_id();
      int s;
      s = $urandom_range(BookDepth - 1);
      for (int i = 0; i < BookDepth; i++)
        if (live[(s + i) % BookDepth]) return oid[(s + i) % BookDepth];
      return $urandom();
    endfunction

    function void predict_place(order_req_t t);
      bit [63:0] sym;
      bit        sd;
      bit [38:0] lim;
      bit [15:0] left, f;
      int        best, n, s;
      if (slot_of(t.id) >= 0) begin add_error(t.id, ERR_DUPLICATE); return; end
      if (t.len > SymbolChars) begin add_error(t.id, ERR_SYM_LONG); return; end
      if (t.len == 0) begin add_error(t.id, ERR_SYM_MISS); return; end
      if (t.side_char != CharBuy && t.side_char != CharSell) begin
        add_error(t.id, ERR_SIDE); return;
      end
      if (t.qty == 0) begin add_error(t.id, ERR_QTY); return; end
      if (t.px <= 0) begin add_error(t.id, ERR_PX); return; end
      sd = (t.side_char == CharSell);
      lim = t.px[38:0];
      sym = t.sym;
      if (t.len < 8) sym &= ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * t.len));
      left = t.qty;
      n = 0;
      while (left > 0 && n + 2 <= MaxResults) begin
        best = -1;
        for (s = 0; s < BookDepth; s++) begin
          if (!live[s] || oside[s] == sd || osym[s] != sym) continue;
          if (sd == 1'b0 ? opx[s] > lim : opx[s] < lim) continue;
          if (best < 0) best = s;
          else if (opx[s] != opx[best]) begin
            if (sd == 1'b0 ? opx[s] < opx[best] : opx[s] > opx[best]) best = s;
          end else if (age(s) > age(best)) best = s;
        end
        if (best < 0) break;
        f = (left < oqty[best]) ? left : oqty[best];
        add(KIND_FILL, t.id, sym, 1'b0, f, opx[best], ERR_ACTION);
        add(KIND_FILL, oid[best], osym[best], 1'b0, f, opx[best], ERR_ACTION);
        fills_seen++;
        n += 2;
        left -= f;
        oqty[best] -= f;
        if (oqty[best] == 0) live[best] = 1'b0;
      end
      if (left > 0) begin
        for (s = 0; s < BookDepth; s++)
          if (!live[s]) break;
        if (s < BookDepth) begin
          live[s] = 1'b1; oid[s] = t.id; osym[s] = sym; oside[s] = sd;
          oqty[s] = left; opx[s] = lim; oarr[s] = arrivals;
          arrivals++;
        end else if (n < MaxResults) add_error(t.id, ERR_FULL);
      end
    endfunction

    function void predict_print(bit [31:0] id);
      int order[$];
      int j, v;
      foreach (live[s]) if (live[s]) order = {order, s};
      if (order.size() == 0) begin add_error(id, ERR_EMPTY); return; end
      for (int i = 1; i < order.size(); i++) begin
        v = order[i];
        j = i;
        while (j > 0 && lists_first(v, order[j - 1])) begin
          order[j] = order[j - 1];
          j--;
        end
        order[j] = v;
      end
      foreach (order[i])
        add(KIND_ENTRY, oid[order[i]], osym[order[i]], oside[order[i]],
            oqty[order[i]], opx[order[i]], ERR_ACTION);
    endfunction

    function void note_input(order_req_t t);
      int base, s;
      base = awaited_q.size();
      case (t.op)
        OP_PLACE: predict_place(t);
        OP_CANCEL: begin
          s = slot_of(t.id);
          if (s < 0) add_error(t.id, ERR_NOT_FOUND);
          else begin
            live[s] = 1'b0;
            add(KIND_CANCEL, t.id, '0, 1'b0, '0, '0, ERR_ACTION);
          end
        end
        OP_PRINT: predict_print(t.id);
        default: add_error(t.id, ERR_ACTION);
      endcase
      if (awaited_q.size() > base) awaited_q[awaited_q.size() - 1].last = 1'b1;
    endfunction

    function bit differs(book_result_t a, book_result_t b);
      return (a.kind !== b.kind) || (a.id !== b.id) || (a.sym !== b.sym) ||
             (a.side !== b.side) || (a.qty !== b.qty) || (a.px !== b.px) ||
             (a.err !== b.err) || (a.last !== b.last);
    endfunction

    function void check_result(book_result_t got);
      book_result_t want;
      results_seen++;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d id %0h", got.kind, got.id);
        return;
      end
      want = awaited_q.pop_front();
      if (differs(got, want)) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected k%0d id%h sym%h s%0d q%0d p%0d e%0d l%0d",
                   want.kind, want.id, want.sym, want.side, want.qty, want.px,
                   want.err, want.last);
          $display("          got      k%0d id%h sym%h s%0d q%0d p%0d e%0d l%0d",
                   got.kind, got.id, got.sym, got.side, got.qty, got.px,
                   got.err, got.last);
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation_i = '0;
  logic [31:0]        order_id_i = '0;
  logic [63:0]        symbol_i = '0;
  logic [3:0]         symbol_length_i = '0;
  logic [7:0]         side_char_i = '0;
  logic [15:0]        quantity_i = '0;
  logic signed [39:0] limit_price_i = '0;
  logic               result_valid_o;
  logic [1:0]         result_kind_o;
  logic [31:0]        result_order_id_o;
  logic [63:0]        result_symbol_o;
  logic               result_side_o;
  logic [15:0]        result_qty_o;
  logic [38:0]        result_price_o;
  logic [3:0]         error_code_o;
  logic               last_of_run_o;

  lob_scoreboard book_sb = new();
  int            accepted_count;
  int            quiet_cycles;
  bit [31:0]     next_id = 32'h100;
  bit            allow_idle = 1'b1;

  limit_order_book_matcher u_top (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .order_id_i, .symbol_i,
    .symbol_length_i, .side_char_i, .quantity_i, .limit_price_i, .result_valid_o,
    .result_kind_o, .result_order_id_o, .result_symbol_o, .result_side_o,
    .result_qty_o, .result_price_o, .error_code_o, .last_of_run_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      book_result_t r;
      r.kind = kind_e'(result_kind_o); r.id = result_order_id_o;
      r.sym = result_symbol_o; r.side = result_side_o; r.qty = result_qty_o;
      r.px = result_price_o; r.err = err_e'(error_code_o); r.last = last_of_run_o;
      book_sb.check_result(r);
    end
  end

  // A transaction in either direction counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(order_req_t t);
    if (allow_idle && $urandom_range(99) < 24) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(5)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    operation_i = t.op; order_id_i = t.id; symbol_i = t.sym;
    symbol_length_i = t.len; side_char_i = t.side_char; quantity_i = t.qty;
    limit_price_i = t.px;
    do @(posedge clk_i); while (busy);
    book_sb.note_input(t);
    accepted_count++;
  endtask

  function automatic order_req_t order(op_e op, bit [31:0] id, bit [63:0] sym,
                                       bit [3:0] len, bit [7:0] sc, bit [15:0] q,
                                       logic signed [39:0] px);
    order_req_t t;
    t.op = op; t.id = id; t.sym = sym; t.len = len; t.side_char = sc; t.qty = q;
    t.px = px;
    return t;
  endfunction

  // Well-formed order on one of three symbols with junk below the given length.
  function automatic order_req_t sane_order();
    bit [63:0] pool[3];
    bit [3:0]  lens[3];
    int        k;
    pool[0] = {"ZQRT", 32'h0}; pool[1] = {"LMNO", 32'h0}; pool[2] = {"PQRSTU", 16'h0};
    lens[0] = 4'd4; lens[1] = 4'd4; lens[2] = 4'd6;
    k = $urandom_range(2);
    next_id++;
    return order(OP_PLACE, next_id,
                 pool[k] | ({$urandom(), $urandom()} >> (8 * lens[k])), lens[k],
                 $urandom_range(1) ? CharSell : CharBuy, 16'($urandom_range(1, 60)),
                 40'sd1000 + 40'($urandom_range(12)));
  endfunction

  function automatic order_req_t noise();
    order_req_t t;
    t = order(op_e'($urandom_range(3)), $urandom(), {$urandom(), $urandom()},
              4'($urandom_range(15)), 8'($urandom_range(255)),
              16'($urandom_range(65535)), 40'({$urandom_range(255), $urandom()}));
    return t;
  endfunction

  initial begin
    order_req_t t;
    bit [63:0] sym;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: every operation, each error and the extremes.
    sym = {"ZQRT", 32'h0};
    send(order(OP_BAD, 32'hFFFF_FFFF, '1, 4'hF, 8'hFF, 16'hFFFF, -40'sd1));
    send(order(OP_PRINT, 32'h0, '0, 0, 0, 0, 0));
    send(order(OP_CANCEL, 32'h55, sym, 4, CharBuy, 1, 1));
    send(order(OP_PLACE, 32'h1, sym, 4, CharSell, 16'hFFFF, 40'sh7F_FFFF_FFFF));
    send(order(OP_PLACE, 32'h1, sym, 4, CharBuy, 5, 100));
    send(order(OP_PLACE, 32'h2, sym, 9, CharBuy, 5, 100));
    send(order(OP_PLACE, 32'h2, sym, 4'hF, CharBuy, 5, 100));
    send(order(OP_PLACE, 32'h2, sym, 0, CharBuy, 5, 100));
    send(order(OP_PLACE, 32'h2, sym, 4, "X", 5, 100));
    send(order(OP_PLACE, 32'h2, sym, 4, CharBuy, 0, 100));
    send(order(OP_PLACE, 32'h2, sym, 4, CharBuy, 5, 0));
    send(order(OP_PLACE, 32'h2, sym, 4, CharBuy, 5, 40'sh80_0000_0000));
    send(order(OP_PLACE, 32'h3, sym | 64'hFF, 4, CharSell, 10, 1));
    send(order(OP_PLACE, 32'h4, sym, 4, CharSell, 10, 1));
    send(order(OP_PLACE, 32'h5, '1, 8, CharBuy, 30, 1));
    send(order(OP_PLACE, 32'h6, sym, 4, CharBuy, 25, 2));
    send(order(OP_PRINT, 32'h7, '0, 0, 0, 0, 0));
    send(order(OP_CANCEL, 32'h1, '0, 0, 0, 0, 0));
    send(order(OP_CANCEL, 32'h1, '0, 0, 0, 0, 0));
    // Fill the store with orders that cannot cross, then overflow it.
    for (int i = 0; i < 17; i++)
      send(order(OP_PLACE, 32'h200 + i, {"LMNO", 32'h0}, 4,
                 (i % 2) ? CharSell : CharBuy, 16'(1 + i),
                 40'((i % 2) ? 500 + i : 100 + i)));
    send(order(OP_PRINT, 32'h8, '0, 0, 0, 0, 0));
    // One large order sweeps every resting sell.
    send(order(OP_PLACE, 32'h300, {"LMNO", 32'h0}, 4, CharBuy, 16'hFFFF, 1000));

    // Random part: mostly sane orders and cancels, some noise and prints.
    for (int i = 0; i < 132; i++) begin
      int pick;
      allow_idle = !(i >= 60 && i < 110);
      if (i == 120) begin
        @(negedge clk_i);
        start = 1'b0;
        while (book_sb.awaited_q.size() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < 55) t = sane_order();
      else if (pick < 78) begin
        t = order(OP_CANCEL, $urandom_range(3) ? book_sb.any_resting_id() : $urandom(),
                  {$urandom(), $urandom()}, 4'($urandom_range(15)),
                  8'($urandom_range(255)), 16'($urandom()), 40'($urandom()));
      end else if (pick < 84) t = order(OP_PRINT, $urandom(), '0, 0, 0, 0, 0);
      else if (pick < 89) begin
        t = sane_order();
        if (book_sb.resting_id_count() > 0) t.id = book_sb.any_resting_id();
      end else t = noise();
      send(t);
    end
    @(negedge clk_i);
    start = 1'b0;

    while (book_sb.awaited_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d transactions; checked %0d results including %0d fill pairs.",
             accepted_count, book_sb.results_seen, book_sb.fills_seen);
    if (book_sb.mismatches == 0 && book_sb.awaited_q.size() == 0)
      $display("[ OK ] regression clean");
    else begin
      $display("%0d mismatches, %0d results never seen", book_sb.mismatches,
               book_sb.awaited_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
